/* hdl/isqr_pkg.sv */
package isqr_pkg;

  // Width of the radicand and of the rounded root.
  localparam int INPUT_WIDTH = 32;
  localparam int ROOT_WIDTH = (INPUT_WIDTH + 1) / 2 + 1;

  // The test bit starts at the highest even position and moves two places per round.
  localparam int TOP_EVEN_BIT = (INPUT_WIDTH - 1) & ~1;
  localparam int NUM_ROUNDS = TOP_EVEN_BIT / 2 + 1;

  // Two rounds are done in each pipeline stage.
  localparam int ROUNDS_PER_STAGE = 2;
  localparam int NUM_STAGES = (NUM_ROUNDS + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;

  // Partial state of one item as it moves down the pipeline.
  typedef struct packed {
    logic [INPUT_WIDTH-1:0] rem;
    logic [INPUT_WIDTH-1:0] acc;
  } isqr_word_t;

  // Test bit of a given round.
  function automatic logic [INPUT_WIDTH-1:0] probe_of(input int round_idx);
    logic [INPUT_WIDTH-1:0] one_bit;
    one_bit = {{(INPUT_WIDTH-1){1'b0}}, 1'b1};
    return one_bit << (TOP_EVEN_BIT - 2 * round_idx);
  endfunction

  // One restoring round: subtract the trial value when it fits, then halve the root.
  function automatic isqr_word_t sqrt_round(input isqr_word_t w,
                                            input logic [INPUT_WIDTH-1:0] probe);
    logic [INPUT_WIDTH:0] trial;
    logic [INPUT_WIDTH:0] acc_sum;
    isqr_word_t res;
    trial = {1'b0, probe} + {1'b0, w.acc};
    res = w;
    if (trial <= {1'b0, w.rem}) begin
      res.rem = w.rem - trial[INPUT_WIDTH-1:0];
      acc_sum = trial + {1'b0, probe};
    end else begin
      acc_sum = {1'b0, w.acc};
    end
    res.acc = acc_sum[INPUT_WIDTH:1];
    return res;
  endfunction

endpackage

/* hdl/isqr_in_if.sv */
interface isqr_in_if
  import isqr_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [INPUT_WIDTH-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink (input valid, input radicand, output ready);
endinterface

/* hdl/isqr_out_if.sv */
interface isqr_out_if
  import isqr_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [ROOT_WIDTH-1:0] root;

  modport source (output valid, output root, input ready);
  modport sink (input valid, input root, output ready);
endinterface

/* hdl/integer_sqrt_rounded_top.sv */
// Rounded integer square root, pipelined.
//
// in_ch carries one unsigned radicand per word; out_ch returns its square root
// rounded to the nearest integer, one word per input word, in order. The top
// input 0xFFFFFFFF gives 65536, so the root is one bit wider than half the input.
// Both channels use valid/ready; a word moves when both are high.
//
// The restoring digit-by-digit method runs sixteen rounds, two per pipeline
// stage, over eight stages; a final stage applies the rounding step and holds
// the output register. While out_ch does not stall, a new word can be accepted
// every cycle, so throughput is one word per cycle, set by the per-stage pair
// of 32-bit compare/subtract rounds.
//
// When out_ch stalls, each stage holds its word and its valid bit; stages that
// are empty still take new words, so in_ch keeps accepting until the pipeline
// is full, and no word is lost or repeated. Reset (rst_n low, synchronous)
// clears all valid bits; the data registers are not reset.
module integer_sqrt_rounded_top
  import isqr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  isqr_in_if.sink    in_ch,
  isqr_out_if.source out_ch
);

  logic       core_valid;
  logic       core_ready;
  isqr_word_t core_word;

  // Rounds of the recurrence.
  isqr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_radicand (in_ch.radicand),
    .down_valid  (core_valid),
    .down_ready  (core_ready),
    .down_word   (core_word)
  );

  // Rounding and output register.
  isqr_final u_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (core_valid),
    .up_ready (core_ready),
    .up_word  (core_word),
    .out_ch   (out_ch)
  );

endmodule

/* hdl/isqr_core.sv */
module isqr_core
  import isqr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [INPUT_WIDTH-1:0] in_radicand,
  output logic                   down_valid,
  input  logic                   down_ready,
  output isqr_word_t             down_word
);

  logic       vld_r [NUM_STAGES];
  isqr_word_t word_r [NUM_STAGES];
  isqr_word_t word_nxt [NUM_STAGES];
  logic       stage_ready [NUM_STAGES];
  isqr_word_t first_word;

  // A new word starts with the whole radicand as remainder and an empty root.
  assign first_word.rem = in_radicand;
  assign first_word.acc = '0;

  assign in_ready = stage_ready[0];
  assign down_valid = vld_r[NUM_STAGES-1];
  assign down_word = word_r[NUM_STAGES-1];

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    localparam int R0 = s * ROUNDS_PER_STAGE;
    localparam logic [INPUT_WIDTH-1:0] P0 = probe_of(R0);
    localparam logic [INPUT_WIDTH-1:0] P1 = probe_of(R0 + 1);

    isqr_word_t src_word;
    isqr_word_t mid_word;
    logic       src_valid;
    logic       next_ready;

    if (s == 0) begin : g_src_in
      assign src_word = first_word;
      assign src_valid = in_valid;
    end else begin : g_src_prev
      assign src_word = word_r[s-1];
      assign src_valid = vld_r[s-1];
    end

    if (s == NUM_STAGES - 1) begin : g_dst_out
      assign next_ready = down_ready;
    end else begin : g_dst_next
      assign next_ready = stage_ready[s+1];
    end

    // A stage takes a word when it is empty or its word moves on.
    assign stage_ready[s] = !vld_r[s] || next_ready;

    // Two rounds of the digit-by-digit recurrence; the last stage may hold only one.
    always_comb begin
      mid_word = sqrt_round(src_word, P0);
      if (R0 + 1 < NUM_ROUNDS) begin
        word_nxt[s] = sqrt_round(mid_word, P1);
      end else begin
        word_nxt[s] = mid_word;
      end
    end

    // Valid bit of the stage.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (stage_ready[s]) begin
        vld_r[s] <= src_valid;
      end
    end

    // Stage data.
    always_ff @(posedge clk) begin
      if (stage_ready[s] && src_valid) begin
        word_r[s] <= word_nxt[s];
      end
    end
  end

endmodule

/* hdl/isqr_final.sv */
module isqr_final
  import isqr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  isqr_word_t up_word,
  isqr_out_if.source out_ch
);

  logic                  out_vld_r;
  logic [ROOT_WIDTH-1:0] root_r;
  logic [ROOT_WIDTH-1:0] root_nxt;
  logic [ROOT_WIDTH-1:0] acc_short;

  // The root fits in ROOT_WIDTH bits before rounding.
  assign acc_short = up_word.acc[ROOT_WIDTH-1:0];

  // Round to nearest: add one when the remainder exceeds the root.
  always_comb begin
    if (up_word.rem > up_word.acc) begin
      root_nxt = acc_short + {{(ROOT_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      root_nxt = acc_short;
    end
  end

  assign up_ready = !out_vld_r || out_ch.ready;

  // Output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (up_ready) begin
      out_vld_r <= up_valid;
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      root_r <= root_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.root = root_r;

endmodule

/* bench/isqr_root_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the rounded square root block, predicts the root of
// every radicand word taken in, and compares each returned word in order.
module isqr_root_checker
  import isqr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       end_of_run,
  isqr_in_if         in_mon,
  isqr_out_if        out_mon,
  output int         fail_count,
  output int         words_pending,
  output int         roots_checked,
  output int         top_roots
);

  // Roots still owed by the block, oldest first.
  logic [ROOT_WIDTH-1:0] expected_roots [$];
  bit leftovers_reported;

  initial begin
    fail_count = 0;
    words_pending = 0;
    roots_checked = 0;
    top_roots = 0;
    leftovers_reported = 1'b0;
  end

  // Restoring digit-by-digit root, then round up when the remainder passes the root.
  function automatic logic [ROOT_WIDTH-1:0] rounded_root(
    input logic [INPUT_WIDTH-1:0] radicand
  );
    logic [INPUT_WIDTH:0] left_over;
    logic [INPUT_WIDTH:0] root_acc;
    logic [INPUT_WIDTH:0] test_bit;
    logic [INPUT_WIDTH:0] trial;
    left_over = {1'b0, radicand};
    root_acc = '0;
    test_bit = '0;
    test_bit[TOP_EVEN_BIT] = 1'b1;
    for (int n = 0; n < NUM_ROUNDS; n++) begin
      trial = root_acc + test_bit;
      if (trial <= left_over) begin
        left_over = left_over - trial;
        root_acc = trial + test_bit;
      end
      root_acc = root_acc >> 1;
      test_bit = test_bit >> 2;
    end
    if (left_over > root_acc) begin
      root_acc = root_acc + 1'b1;
    end
    return root_acc[ROOT_WIDTH-1:0];
  endfunction

  // Prints one line per problem, up to a cap, and counts every one.
  task automatic report_mismatch(input string msg);
    if (fail_count < 30) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    fail_count++;
  endtask

  // Both handshakes are sampled at the rising edge, before any driver updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        expected_roots.push_back(rounded_root(in_mon.radicand));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_roots.size() == 0) begin
          report_mismatch($sformatf("root word %0d arrived with none expected",
                                    out_mon.root));
        end else begin
          if (out_mon.root !== expected_roots[0]) begin
            report_mismatch($sformatf("root: expected %0d, got %0d",
                                      expected_roots[0], out_mon.root));
          end
          if (expected_roots[0] == (1 << (ROOT_WIDTH - 1))) begin
            top_roots++;
          end
          void'(expected_roots.pop_front());
        end
        roots_checked++;
      end
      words_pending = expected_roots.size();
    end

    // Whatever is still owed once the run winds down never came back.
    if (end_of_run && !leftovers_reported) begin
      leftovers_reported = 1'b1;
      foreach (expected_roots[i]) begin
        report_mismatch($sformatf("root %0d never returned", expected_roots[i]));
      end
    end
  end

endmodule

/* bench/tb_integer_sqrt_rounded_top.sv */
`timescale 1ns / 1ps

module tb_integer_sqrt_rounded_top;
  import isqr_pkg::*;

  // Flavors of random radicand.
  typedef enum int {
    KIND_ANY,
    KIND_MIDPOINT,
    KIND_SQUARE,
    KIND_SMALL,
    KIND_TOP
  } radicand_kind_t;

  localparam int NUM_PHASES = 7;
  localparam int WORDS_PER_PHASE = 190;
  localparam int NUM_CORNERS = 22;

  // Zero, tiny values, rounding edges around small and largest squares, and all-ones.
  localparam logic [INPUT_WIDTH-1:0] CORNERS [NUM_CORNERS] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
    32'h0000_0004, 32'h0000_0006, 32'h0000_0007, 32'h0000_000C,
    32'h0000_000D, 32'h0000_0010, 32'h3FFF_FFFF, 32'h4000_0000,
    32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFE_0001,
    32'hFFFF_0000, 32'hFFFF_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
    32'h7FFF_FFFF, 32'hFFFE_FFFF
  };

  logic clk = 1'b0;
  logic rst_n;
  logic end_of_run;
  bit   source_burst;
  bit   sink_burst;
  int   stall_left;
  int   sink_wait;
  int   words_sent;
  int   fail_count;
  int   words_pending;
  int   roots_checked;
  int   top_roots;

  isqr_in_if  in_ch ();
  isqr_out_if out_ch ();

  integer_sqrt_rounded_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  isqr_root_checker u_root_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .end_of_run    (end_of_run),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .roots_checked (roots_checked),
    .top_roots     (top_roots)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("Run timed out with %0d roots still owed.", words_pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: outside sink bursts, after each word taken, draw a random wait (which may be zero) and hold ready low.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (!out_ch.ready) begin
      if (stall_left <= 1) begin
        out_ch.ready <= 1'b1;
        stall_left <= 0;
      end else begin
        stall_left <= stall_left - 1;
      end
    end else if (out_ch.valid && !sink_burst) begin
      sink_wait = $urandom_range(0, 9);
      if (sink_wait > 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= sink_wait;
      end
    end
  end

  // Presents one radicand after an optional gap and waits until it is taken.
  task automatic send_word(input logic [INPUT_WIDTH-1:0] radicand, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.radicand <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.radicand <= radicand;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Biased radicand: random words and values near squares and rounding midpoints, plus small and top values.
  function automatic logic [INPUT_WIDTH-1:0] pick_radicand();
    radicand_kind_t kind;
    longint unsigned base;
    longint unsigned r;
    int pick;
    pick = $urandom_range(0, 9);
    kind = (pick < 4) ? KIND_ANY : (pick < 7) ? KIND_MIDPOINT :
           (pick < 8) ? KIND_SQUARE : (pick < 9) ? KIND_SMALL : KIND_TOP;
    r = $urandom_range(0, 65535);
    case (kind)
      KIND_MIDPOINT: begin
        base = r * r + r + $urandom_range(0, 2);
        base = (base == 0) ? 0 : base - 1;
      end
      KIND_SQUARE: begin
        base = r * r + $urandom_range(0, 2);
        base = (base == 0) ? 0 : base - 1;
      end
      KIND_SMALL: base = $urandom_range(0, 4095);
      KIND_TOP: base = {32'h0, 16'hFFFF, 16'($urandom)};
      default: base = {32'h0, $urandom};
    endcase
    if (base > 64'hFFFF_FFFF) begin
      base = 64'hFFFF_FFFF;
    end
    return base[INPUT_WIDTH-1:0];
  endfunction

  initial begin : stimulus
    int guard;
    in_ch.valid = 1'b0;
    in_ch.radicand = '0;
    rst_n = 1'b0;
    end_of_run = 1'b0;
    source_burst = 1'b0;
    sink_burst = 1'b0;
    words_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners, with gaps on some of them.
    foreach (CORNERS[i]) begin
      send_word(CORNERS[i], (i % 3 == 0) ? $urandom_range(0, 9) : 0);
    end

    // Let the pipeline drain completely before the random phases.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);

    // Random phases cycle through full speed, and stalls on either or both sides.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      source_burst = (phase % 4 == 0) || (phase % 4 == 2);
      sink_burst = (phase % 4 == 0) || (phase % 4 == 1);
      if (phase == 3) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        send_word(pick_radicand(), source_burst ? 0 : $urandom_range(0, 9));
      end
    end
    in_ch.valid <= 1'b0;
    sink_burst = 1'b0;

    // Wait for the last roots, then keep watching for stray words before the run ends.
    guard = 0;
    @(posedge clk);
    while (words_pending != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Sent %0d radicands (corners, near-square and midpoint values, random words);",
             words_sent);
    $display("checked %0d roots, %0d of them at the top value, under mixed stalls.",
             roots_checked, top_roots);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/isqr_pkg.sv
hdl/isqr_in_if.sv
hdl/isqr_out_if.sv
hdl/isqr_core.sv
hdl/isqr_final.sv
hdl/integer_sqrt_rounded_top.sv
bench/isqr_root_checker.sv
bench/tb_integer_sqrt_rounded_top.sv
